>>> hdl/integer_square_root_core_defines.svh
// Assertion macros shared by the square root core.
`ifndef INTEGER_SQUARE_ROOT_CORE_DEFINES_SVH
`define INTEGER_SQUARE_ROOT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check a property outside reset.
`define ISQRT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Check a property at every edge, reset included.
`define ISQRT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ISQRT_ASSERT(label, prop, msg)
`define ISQRT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

>>> hdl/isqrt_pkg.sv
package isqrt_pkg;

   // Result width and saturation value
   localparam int ROOT_WIDTH = 16;
   localparam logic [ROOT_WIDTH-1:0] ROOT_MAX = {ROOT_WIDTH{1'b1}};

   typedef logic [ROOT_WIDTH-1:0] root_type;

endpackage

>>> hdl/isqrt_if.sv
// Radicand channel
interface isqrt_req_if #(
   parameter int IN_WIDTH = 32
);
   logic                valid;
   logic                ready;
   logic [IN_WIDTH-1:0] radicand;

   modport source (output valid, output radicand, input ready);
   modport sink   (input valid, input radicand, output ready);
endinterface

// Root channel
interface isqrt_rsp_if;
   logic                valid;
   logic                ready;
   isqrt_pkg::root_type root;

   modport source (output valid, output root, input ready);
   modport sink   (input valid, input root, output ready);
endinterface

>>> hdl/integer_square_root_core.sv
// Channel   Dir   Payload             Transfer
// req       in    radicand[W-1:0]     req.valid && req.ready
// rsp       out   root[15:0]          rsp.valid && rsp.ready
//
// One radicand is taken per cycle while the result is not stalled; each root passes
// through one register per cell of the digit chain (16 cells at the default width).
// Reset clears the valid flag of every cell; data registers are not reset.
// A stalled result freezes the whole chain, and req.ready falls with it.
// The final cell is the output register.
`include "integer_square_root_core_defines.svh"

module integer_square_root_core #(
   parameter int IN_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   isqrt_req_if.sink   req,
   isqrt_rsp_if.source rsp
);

   localparam int ROOT_BITS = IN_WIDTH / 2;

   logic                advance;
   logic [ROOT_BITS:0]  stage_valid;
   logic [IN_WIDTH-1:0] stage_rem [ROOT_BITS+1];
   logic [IN_WIDTH-1:0] stage_acc [ROOT_BITS+1];
   logic [IN_WIDTH-1:0] last_rem;
   logic [IN_WIDTH-1:0] last_acc;

   // Move the chain whenever the output register is free or being drained
   assign advance   = !stage_valid[ROOT_BITS] || rsp.ready;
   assign req.ready = advance;

   // Feed the first cell; a negative radicand starts from zero
   assign stage_valid[0] = req.valid;
   assign stage_rem[0]   = req.radicand[IN_WIDTH-1] ? '0 : req.radicand;
   assign stage_acc[0]   = '0;

   // Build the chain, trial bit falling by two positions per cell
   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_cell
      isqrt_cell #(
         .IN_WIDTH (IN_WIDTH),
         .SHIFT    (2 * (ROOT_BITS - 1 - k))
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (stage_valid[k]),
         .in_rem    (stage_rem[k]),
         .in_acc    (stage_acc[k]),
         .out_valid (stage_valid[k+1]),
         .out_rem   (stage_rem[k+1]),
         .out_acc   (stage_acc[k+1])
      );
   end

   assign last_rem  = stage_rem[ROOT_BITS];
   assign last_acc  = stage_acc[ROOT_BITS];
   assign rsp.valid = stage_valid[ROOT_BITS];

   // Fit the root to the result width, saturating on wide radicands
   if (ROOT_BITS <= isqrt_pkg::ROOT_WIDTH) begin : g_fit
      assign rsp.root = isqrt_pkg::ROOT_WIDTH'(last_acc[ROOT_BITS-1:0]);
   end else begin : g_sat
      assign rsp.root = (|last_acc[ROOT_BITS-1:isqrt_pkg::ROOT_WIDTH])
                        ? isqrt_pkg::ROOT_MAX
                        : last_acc[isqrt_pkg::ROOT_WIDTH-1:0];
   end

   // Checks
   `ISQRT_ASSERT(a_accept_enters_chain, (req.valid && req.ready) |=> stage_valid[1], "accepted radicand did not enter the first cell")
   `ISQRT_ASSERT(a_stall_freezes_chain, !advance |=> $stable(stage_valid[ROOT_BITS:1]), "chain moved while the result was stalled")
   `ISQRT_ASSERT(a_root_is_floor, rsp.valid |-> ({1'b0, last_rem} <= {last_acc, 1'b0}), "remainder exceeds twice the root")
   `ISQRT_ASSERT_ALWAYS(a_reset_empties_chain, reset |=> (stage_valid[ROOT_BITS:1] == '0), "chain not empty after reset")

endmodule

>>> hdl/isqrt_cell.sv
// One digit step of the square root: compare, subtract, shift.
module isqrt_cell #(
   parameter int IN_WIDTH = 32,
   parameter int SHIFT    = 30
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [IN_WIDTH-1:0] in_rem,
   input  logic [IN_WIDTH-1:0] in_acc,
   output logic                out_valid,
   output logic [IN_WIDTH-1:0] out_rem,
   output logic [IN_WIDTH-1:0] out_acc
);

   localparam logic [IN_WIDTH-1:0] TRIAL = {{(IN_WIDTH-1){1'b0}}, 1'b1} << SHIFT;

   logic                valid_ff;
   logic [IN_WIDTH-1:0] rem_ff;
   logic [IN_WIDTH-1:0] acc_ff;
   logic [IN_WIDTH-1:0] rem_in;
   logic [IN_WIDTH-1:0] acc_in;
   logic [IN_WIDTH:0]   cand;
   logic                take;

   // Trial subtract of root plus bit
   always_comb begin
      cand = {1'b0, in_acc} + {1'b0, TRIAL};
      take = ({1'b0, in_rem} >= cand);
      if (take) begin
         rem_in = in_rem - cand[IN_WIDTH-1:0];
         acc_in = (in_acc >> 1) + TRIAL;
      end else begin
         rem_in = in_rem;
         acc_in = in_acc >> 1;
      end
   end

   // Hand the step on to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         rem_ff <= rem_in;
         acc_ff <= acc_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_acc   = acc_ff;

endmodule
